>>> design/upc_pkg.sv
// Package for the URL percent codec: byte type, mode codes, character constants
// and the reserved-character and hex-digit helper functions.
// No dependencies.
`default_nettype none

package upc_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;
    localparam logic        REG_MODE = 1'b0;

    localparam byte_t CH_PCT = 8'h25;

    // Lowest and highest first hex digit used by any listed code.
    localparam byte_t CH_D2 = 8'h32;
    localparam byte_t CH_D7 = 8'h37;

    // The 29 characters that are percent-encoded.
    function automatic logic is_reserved(input byte_t b);
        logic hit;
        case (b)
            8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
            8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D,
            8'h20, 8'h22, 8'h3C, 8'h3E, 8'h5C, 8'h5E, 8'h60, 8'h7B, 8'h7C,
            8'h7D, 8'h7E: hit = 1'b1;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Uppercase hex digit of a nibble.
    function automatic byte_t hex_digit(input logic [3:0] n);
        byte_t d;
        if (n < 4'd10)
        begin
            d = 8'h30 + {4'h0, n};
        end
        else
        begin
            d = 8'h37 + {4'h0, n};
        end
        return d;
    endfunction

    // Value of an uppercase hex digit: {valid, nibble}.
    function automatic logic [4:0] hex_value(input byte_t c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b1, c[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        else
        begin
            v = 5'h00;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/url_percent_codec.sv
// URL percent codec. An accepted word is registered in the input register, and its
// results are loaded into the result register once that register is empty or emptying.
// The result register holds up to three bytes and gives one output word per cycle
// while out_ready is high. An encoded reserved character gives three words; bytes of
// a held decode prefix stay in the block until more bytes arrive.
// Reset clears mode to encode and drops held bytes.
// Depends on upc_pkg.
`default_nettype none

module url_percent_codec
(
    input  wire                             clk,
    input  wire                             rst_n,

    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [upc_pkg::ADDR_W-1:0]      paddr,
    input  wire  [upc_pkg::DATA_W-1:0]      pwdata,
    output logic [upc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,

    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [7:0]                      in_byte,
    input  wire                             in_last,

    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [7:0]                      out_byte,
    output logic                            out_last
);

    upc_pkg::mode_t  mode_reg;
    logic            item_valid_reg;
    upc_pkg::byte_t  item_byte_reg;
    logic            item_last_reg;
    upc_pkg::byte_t  held_bytes_reg [0:1];
    logic [1:0]      held_count_reg;
    upc_pkg::byte_t  res_bytes_reg [0:2];
    logic [1:0]      res_count_reg;
    logic            res_last_reg;

    upc_pkg::byte_t  res_bytes_next [0:2];
    logic [1:0]      res_count_next;
    upc_pkg::byte_t  held_bytes_next [0:1];
    logic [1:0]      held_count_next;

    logic            cfg_write;
    logic            process;
    logic            drain;

    upc_pkg::byte_t  win [0:3];
    logic [1:0]      win_len;
    logic [1:0]      pos;
    logic [1:0]      rem;
    logic            done;
    logic [4:0]      hv1;
    logic [4:0]      hv2;
    upc_pkg::byte_t  code_ch;
    logic            full_hit;
    logic            prefix_hit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == upc_pkg::REG_MODE);
    assign prdata    = (paddr[2] == upc_pkg::REG_MODE) ?
                       {{(upc_pkg::DATA_W-1){1'b0}}, mode_reg} : '0;

    assign out_valid = (res_count_reg != 2'd0);
    assign out_byte  = res_bytes_reg[0];
    assign out_last  = res_last_reg && (res_count_reg == 2'd1);
    assign drain     = out_valid && out_ready;

    // Process the held word once the result register is empty or emptying.
    assign process  = item_valid_reg &&
                      ((res_count_reg == 2'd0) || ((res_count_reg == 2'd1) && out_ready));
    assign in_ready = !item_valid_reg || process;

    // Decode window: held prefix followed by the new byte.
    always_comb
    begin
        win[3] = 8'h00;
        case (held_count_reg)
            2'd1:
            begin
                win[0] = held_bytes_reg[0];
                win[1] = item_byte_reg;
                win[2] = 8'h00;
            end
            2'd2:
            begin
                win[0] = held_bytes_reg[0];
                win[1] = held_bytes_reg[1];
                win[2] = item_byte_reg;
            end
            default:
            begin
                win[0] = item_byte_reg;
                win[1] = 8'h00;
                win[2] = 8'h00;
            end
        endcase
        win_len = held_count_reg + 2'd1;
    end

    assign hv1      = upc_pkg::hex_value(win[1]);
    assign hv2      = upc_pkg::hex_value(win[2]);
    assign code_ch  = {hv1[3:0], hv2[3:0]};
    assign full_hit = (win[0] == upc_pkg::CH_PCT) && hv1[4] && hv2[4] &&
                      upc_pkg::is_reserved(code_ch);

    always_comb
    begin
        res_bytes_next[0]  = 8'h00;
        res_bytes_next[1]  = 8'h00;
        res_bytes_next[2]  = 8'h00;
        res_count_next     = 2'd0;
        held_bytes_next[0] = held_bytes_reg[0];
        held_bytes_next[1] = held_bytes_reg[1];
        held_count_next    = 2'd0;
        pos                = 2'd0;
        rem                = 2'd0;
        done               = 1'b0;
        prefix_hit         = 1'b0;

        if (mode_reg == upc_pkg::MODE_ENCODE)
        begin
            if (upc_pkg::is_reserved(item_byte_reg))
            begin
                res_bytes_next[0] = upc_pkg::CH_PCT;
                res_bytes_next[1] = upc_pkg::hex_digit(item_byte_reg[7:4]);
                res_bytes_next[2] = upc_pkg::hex_digit(item_byte_reg[3:0]);
                res_count_next    = 2'd3;
            end
            else
            begin
                res_bytes_next[0] = item_byte_reg;
                res_count_next    = 2'd1;
            end
        end
        else
        begin
            // Greedy scan; every step consumes at least one window byte or holds the rest.
            for (int s = 0; s < 3; s++)
            begin
                if (!done && (pos < win_len))
                begin
                    rem        = win_len - pos;
                    prefix_hit = (rem == 2'd1) ||
                                 ((win[pos + 2'd1] >= upc_pkg::CH_D2) &&
                                  (win[pos + 2'd1] <= upc_pkg::CH_D7));
                    if (win[pos] != upc_pkg::CH_PCT)
                    begin
                        res_bytes_next[res_count_next] = win[pos];
                        res_count_next = res_count_next + 2'd1;
                        pos = pos + 2'd1;
                    end
                    else if (rem == 2'd3)
                    begin
                        if (full_hit)
                        begin
                            res_bytes_next[res_count_next] = code_ch;
                            pos = pos + 2'd3;
                        end
                        else
                        begin
                            res_bytes_next[res_count_next] = upc_pkg::CH_PCT;
                            pos = pos + 2'd1;
                        end
                        res_count_next = res_count_next + 2'd1;
                    end
                    else if (!item_last_reg && prefix_hit)
                    begin
                        // Hold the partial code until more bytes arrive.
                        held_bytes_next[0] = win[pos];
                        held_bytes_next[1] = win[pos + 2'd1];
                        held_count_next    = rem;
                        done               = 1'b1;
                    end
                    else
                    begin
                        res_bytes_next[res_count_next] = upc_pkg::CH_PCT;
                        res_count_next = res_count_next + 2'd1;
                        pos = pos + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= upc_pkg::MODE_ENCODE;
            item_valid_reg    <= 1'b0;
            held_count_reg    <= 2'd0;
            held_bytes_reg[0] <= 8'h00;
            held_bytes_reg[1] <= 8'h00;
            res_count_reg     <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                item_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                mode_reg       <= upc_pkg::mode_t'(pwdata[0]);
                held_count_reg <= 2'd0;
            end
            else if (process)
            begin
                held_count_reg    <= held_count_next;
                held_bytes_reg[0] <= held_bytes_next[0];
                held_bytes_reg[1] <= held_bytes_next[1];
            end

            if (process)
            begin
                res_count_reg <= res_count_next;
            end
            else if (drain)
            begin
                res_count_reg <= res_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_byte_reg <= in_byte;
            item_last_reg <= in_last;
        end

        if (process)
        begin
            res_bytes_reg[0] <= res_bytes_next[0];
            res_bytes_reg[1] <= res_bytes_next[1];
            res_bytes_reg[2] <= res_bytes_next[2];
            res_last_reg     <= item_last_reg;
        end
        else if (drain)
        begin
            // Advance the next byte to the head.
            res_bytes_reg[0] <= res_bytes_reg[1];
            res_bytes_reg[1] <= res_bytes_reg[2];
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_codec: encode and decode streams with random stalls.
// Predicts every output word and compares it in order with what the block returns.
// Depends on upc_pkg and url_percent_codec.

module tb_top;

    typedef struct packed
    {
        upc_pkg::byte_t b;
        logic           last;
    } word_t;

    localparam logic [upc_pkg::ADDR_W-1:0] MODE_ADDR  = {upc_pkg::REG_MODE, 2'b00};
    localparam logic [upc_pkg::ADDR_W-1:0] SPARE_ADDR = 3'd4;
    localparam int                         NRSV       = 29;
    localparam int                         TAIL_WAIT  = 8;

    // Reserved characters, first one in the top byte.
    localparam logic [8*NRSV-1:0] RSV_SET =
    {
        8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
        8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D, 8'h20, 8'h22,
        8'h3C, 8'h3E, 8'h5C, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
    };
    localparam logic [127:0] HEX_CHARS = "0123456789ABCDEF";

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [upc_pkg::ADDR_W-1:0] paddr = '0;
    logic [upc_pkg::DATA_W-1:0] pwdata = '0;
    logic [upc_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 in_byte = 8'h00;
    logic                       in_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [7:0]                 out_byte;
    logic                       out_last;

    word_t                      pending_bytes[$];
    word_t                      expected_words[$];
    int unsigned                in_accepted = 0;
    int unsigned                in_issued = 0;
    int                         errors = 0;
    bit                         steady = 1'b0;

    // Predictor state.
    upc_pkg::mode_t             cur_mode = upc_pkg::MODE_ENCODE;
    upc_pkg::byte_t             held[2];
    int                         held_n = 0;

    url_percent_codec dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic upc_pkg::byte_t rsv_at(input int i);
        return RSV_SET[8*(NRSV-1-i) +: 8];
    endfunction

    function automatic upc_pkg::byte_t nibble_char(input logic [3:0] n);
        return HEX_CHARS[8*(15-n) +: 8];
    endfunction

    function automatic bit reserved_char(input upc_pkg::byte_t c);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < NRSV; i++)
        begin
            if (rsv_at(i) == c)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Index of the first reserved character whose code starts with len bytes of c0..c2.
    function automatic int code_prefix(input upc_pkg::byte_t c0, input upc_pkg::byte_t c1,
                                       input upc_pkg::byte_t c2, input int len);
        upc_pkg::byte_t code[3];
        upc_pkg::byte_t w[3];
        upc_pkg::byte_t rc;
        int             found;
        bit             ok;
        found = -1;
        w[0] = c0;
        w[1] = c1;
        w[2] = c2;
        for (int i = 0; i < NRSV && found < 0; i++)
        begin
            rc = rsv_at(i);
            code[0] = upc_pkg::CH_PCT;
            code[1] = nibble_char(rc[7:4]);
            code[2] = nibble_char(rc[3:0]);
            ok = 1'b1;
            for (int k = 0; k < len; k++)
            begin
                if (code[k] != w[k])
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                found = i;
            end
        end
        return found;
    endfunction

    // Work out the output words of one accepted input word and queue them.
    function automatic void codec_predict(input upc_pkg::byte_t b, input logic last);
        upc_pkg::byte_t win[5];
        upc_pkg::byte_t outs[$];
        int             n;
        int             pos;
        int             rem;
        int             m;
        bit             holding;
        word_t          w;
        if (cur_mode == upc_pkg::MODE_ENCODE)
        begin
            if (reserved_char(b))
            begin
                outs = {outs, upc_pkg::CH_PCT};
                outs = {outs, nibble_char(b[7:4])};
                outs = {outs, nibble_char(b[3:0])};
            end
            else
            begin
                outs = {outs, b};
            end
            held_n = 0;
        end
        else
        begin
            for (int k = 0; k < 5; k++)
            begin
                win[k] = 8'h00;
            end
            n = 0;
            for (int k = 0; k < held_n; k++)
            begin
                win[n] = held[k];
                n++;
            end
            win[n] = b;
            n++;
            pos = 0;
            holding = 1'b0;
            while (pos < n && !holding)
            begin
                rem = n - pos;
                if (win[pos] != upc_pkg::CH_PCT)
                begin
                    outs = {outs, win[pos]};
                    pos++;
                end
                else if (rem == 3)
                begin
                    m = code_prefix(win[pos], win[pos+1], win[pos+2], 3);
                    if (m >= 0)
                    begin
                        outs = {outs, rsv_at(m)};
                        pos += 3;
                    end
                    else
                    begin
                        outs = {outs, upc_pkg::CH_PCT};
                        pos++;
                    end
                end
                else if (!last && code_prefix(win[pos], win[pos+1], win[pos+2], rem) >= 0)
                begin
                    // hold the prefix until the code completes or breaks
                    for (int k = 0; k < rem; k++)
                    begin
                        held[k] = win[pos+k];
                    end
                    held_n = rem;
                    holding = 1'b1;
                end
                else
                begin
                    outs = {outs, upc_pkg::CH_PCT};
                    pos++;
                end
            end
            if (!holding)
            begin
                held_n = 0;
            end
        end
        for (int k = 0; k < outs.size(); k++)
        begin
            w.b = outs[k];
            w.last = last && (k == outs.size() - 1);
            expected_words = {expected_words, w};
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
        begin
            return 0;
        end
        else if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Input side: present queued words, hold each until it is taken.
    always @(negedge clk)
    begin : stream_driver
        logic  nv;
        word_t it;
        int    in_gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            nv = in_valid;
            if (in_valid && in_accepted == in_issued)
            begin
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                end
                else if (pending_bytes.size() != 0)
                begin
                    it = pending_bytes.pop_front();
                    in_byte <= it.b;
                    in_last <= it.last;
                    nv = 1'b1;
                    in_issued++;
                    in_gap = pick_gap();
                end
            end
            in_valid <= nv;
        end
    end

    always @(negedge clk)
    begin : out_stall_gen
        int out_hold;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold = 0;
        end
        else if (out_hold > 0)
        begin
            out_ready <= 1'b0;
            out_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
            out_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    always @(posedge clk)
    begin : monitor
        word_t exp_w;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                in_accepted++;
                codec_predict(in_byte, in_last);
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word byte %h last %b", $time, out_byte, out_last);
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_byte !== exp_w.b)
                    begin
                        $display("%0t: out_byte expected %h actual %h", $time, exp_w.b, out_byte);
                        errors++;
                    end
                    if (out_last !== exp_w.last)
                    begin
                        $display("%0t: out_last expected %b actual %b", $time, exp_w.last,
                                 out_last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic reg_write(input logic [upc_pkg::ADDR_W-1:0] a,
                             input logic [upc_pkg::DATA_W-1:0] d);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (a == MODE_ADDR)
        begin
            cur_mode = upc_pkg::mode_t'(d[0]);
            held_n = 0;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_byte(input upc_pkg::byte_t b, input logic last);
        word_t w;
        w.b = b;
        w.last = last;
        pending_bytes = {pending_bytes, w};
    endtask

    task automatic queue_text(input string s, input logic mark_end);
        for (int i = 0; i < s.len(); i++)
        begin
            queue_byte(s[i], mark_end && (i == s.len() - 1));
        end
    endtask

    function automatic logic rand_last();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // Wait for every word to go through, then let the pipeline settle.
    task automatic drain();
        do
        begin
            while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (TAIL_WAIT) @(posedge clk);
        end
        while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0);
    endtask

    initial
    begin : stimulus
        int             count;
        int             r;
        upc_pkg::byte_t c;
        bit             dec;
        logic [31:0]    cfg_rand;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Encode: extremes, reserved, plain and the percent sign itself.
        reg_write(MODE_ADDR, 32'h0000_0000);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_text("!~%\\ A", 1'b1);
        drain();

        // Decode: good codes, mismatch rescan, lowercase, unlisted, flushes.
        reg_write(MODE_ADDR, 32'hFFFF_FFFE | 32'h1);
        queue_text("%21%%2A", 1'b0);
        queue_text("%2a%41", 1'b0);
        queue_text("%7E", 1'b1);
        queue_text("%2", 1'b1);
        queue_text("%", 1'b1);
        drain();

        // A write to an unused address leaves the held prefix alone.
        queue_text("%2", 1'b0);
        drain();
        reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
        queue_text("1", 1'b1);
        drain();

        // A mode write drops the held prefix.
        queue_text("%3", 1'b0);
        drain();
        reg_write(MODE_ADDR, 32'hFFFF_FFFF);
        queue_text("F", 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            dec = (ph % 3 != 0);
            steady = ($urandom_range(0, 3) == 0);
            cfg_rand = $urandom();
            reg_write(MODE_ADDR, {cfg_rand[30:0], dec});
            count = 0;
            while (count < 53)
            begin
                r = $urandom_range(0, 99);
                if (!dec)
                begin
                    if (r < 50)
                    begin
                        queue_byte(rsv_at($urandom_range(0, NRSV-1)), rand_last());
                    end
                    else
                    begin
                        queue_byte(8'($urandom_range(0, 255)), rand_last());
                    end
                    count++;
                end
                else if (r < 50)
                begin
                    c = rsv_at($urandom_range(0, NRSV-1));
                    queue_byte(upc_pkg::CH_PCT, rand_last());
                    queue_byte(nibble_char(c[7:4]), rand_last());
                    queue_byte(nibble_char(c[3:0]), rand_last());
                    count += 3;
                end
                else if (r < 62)
                begin
                    // broken code: odd digit, lowercase or a stray third byte
                    queue_byte(upc_pkg::CH_PCT, rand_last());
                    if ($urandom_range(0, 1))
                    begin
                        queue_byte(8'($urandom_range(upc_pkg::CH_D2, upc_pkg::CH_D7)),
                                   rand_last());
                    end
                    else
                    begin
                        queue_byte(8'($urandom_range(0, 255)), rand_last());
                    end
                    queue_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h66))
                                                    : 8'($urandom_range(0, 255)), rand_last());
                    count += 3;
                end
                else if (r < 70)
                begin
                    queue_byte(upc_pkg::CH_PCT, rand_last());
                    queue_byte(upc_pkg::CH_PCT, rand_last());
                    count += 2;
                end
                else
                begin
                    queue_byte(8'($urandom_range(0, 255)), rand_last());
                    count++;
                end
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
